FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Word layouts, status codes, field widths and the priority ceiling.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_W  = 15;
	localparam int PRIO_W   = 4;
	localparam int CAPACITY = 64;
	localparam int LEVELS   = 16;

	// highest priority kept; requests above it saturate
	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(LEVELS - 1);

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_POP    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		mode_t               mode;
		logic [VALUE_W-1:0]  value;
		logic [PRIO_W-1:0]   priority_req;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  value_out;
	} rsp_t;

	// one stored entry of the chain
	typedef struct packed {
		logic                valid;
		logic [PRIO_W-1:0]   prio;
		logic [VALUE_W-1:0]  value;
	} entry_t;

	// operation broadcast to every cell at once
	typedef struct packed {
		logic                ins;
		logic                pop;
		logic [PRIO_W-1:0]   prio;
		logic [VALUE_W-1:0]  value;
	} op_t;

endpackage

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's entry; on pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::op_t    op,
	input  spq_pkg::entry_t left_entry,
	input  logic            left_keep,
	input  spq_pkg::entry_t right_entry,
	output spq_pkg::entry_t entry,
	output logic            keep
);

	logic                        valid_q;
	logic [spq_pkg::PRIO_W-1:0]  prio_q;
	logic [spq_pkg::VALUE_W-1:0] value_q;

	// stay put when the stored entry ranks at or above the new one (older wins ties)
	assign keep = valid_q && (prio_q >= op.prio);

	assign entry.valid = valid_q;
	assign entry.prio  = prio_q;
	assign entry.value = value_q;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.pop) begin
			valid_q <= right_entry.valid;
		end else if (op.ins && !keep) begin
			valid_q <= left_keep ? 1'b1 : left_entry.valid;
		end
	end

	// move payload: shift left on pop, shift right or load on insert
	always_ff @(posedge clk) begin
		if (op.pop) begin
			prio_q  <= right_entry.prio;
			value_q <= right_entry.value;
		end else if (op.ins && !keep) begin
			if (left_keep) begin
				prio_q  <= op.prio;
				value_q <= op.value;
			end else begin
				prio_q  <= left_entry.prio;
				value_q <= left_entry.value;
			end
		end
	end

endmodule

FILE: design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue built as a sorted cell chain
// Each request word either inserts a value with a priority or pops the head.
// Entries are ordered highest priority first; equal priorities leave oldest
// first. Every cell compares against the request at once, so the whole chain
// shifts in the cycle the word is accepted.
//
// Channels: req (req_valid/req_ready) carries mode, value and priority_req;
// rsp (rsp_valid/rsp_ready) carries status and value_out.
// A pop answers with the head value (ST_OK) or ST_EMPTY; an insert into a
// full queue is dropped and answers ST_FULL; any other insert gives no word.
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle, limited only by the single response
// register; while a response waits on rsp_ready no request is taken.
// Priorities above LEVELS-1 saturate. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::entry_t             cells [CAPACITY];
	logic [CAPACITY-1:0]         keeps;
	logic [CAPACITY-1:0]         vld;
	spq_pkg::op_t                op;
	logic                        accept;
	logic                        full;
	logic                        empty;
	logic [spq_pkg::PRIO_W-1:0]  prio_sat;
	logic                        rsp_valid_q;
	spq_pkg::rsp_t               rsp_q;

	// take a new word whenever the response register is free or draining
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = vld[CAPACITY-1];
	assign empty     = !vld[0];

	// saturate the requested priority
	assign prio_sat = (req.priority_req > spq_pkg::PRIO_MAX) ? spq_pkg::PRIO_MAX
		: req.priority_req;

	// broadcast the operation; drop inserts into a full chain and pops of an empty one
	assign op.ins   = accept && (req.mode == spq_pkg::MODE_INSERT) && !full;
	assign op.pop   = accept && (req.mode == spq_pkg::MODE_POP) && !empty;
	assign op.prio  = prio_sat;
	assign op.value = req.value;

	// build the chain: a virtual keeping head on the left, an empty tail on the right
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_k;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cells[i-1];
			assign left_k = keeps[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = cells[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.entry       (cells[i]),
			.keep        (keeps[i])
		);

		assign vld[i] = cells[i].valid;
	end

	// hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= (req.mode == spq_pkg::MODE_POP) || full;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// capture status and head value
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.mode == spq_pkg::MODE_INSERT) begin
				rsp_q.status    <= spq_pkg::ST_FULL;
				rsp_q.value_out <= '0;
			end else if (empty) begin
				rsp_q.status    <= spq_pkg::ST_EMPTY;
				rsp_q.value_out <= '0;
			end else begin
				rsp_q.status    <= spq_pkg::ST_OK;
				rsp_q.value_out <= cells[0].value;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks on chain ordering and response generation
	logic [CAPACITY-1:0] sorted_ok;
	assign sorted_ok[CAPACITY-1] = 1'b1;
	for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_sort
		assign sorted_ok[j] = !vld[j+1] || (cells[j].prio >= cells[j+1].prio);
	end

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(vld & (vld + CAPACITY'(1))) == '0)
		else $error("occupied cells are not packed at the head");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&sorted_ok)
		else $error("chain priorities are out of order");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |=> rsp_valid && rsp.status == spq_pkg::ST_OK)
		else $error("pop of a nonempty queue gave no valid head");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> $countones(vld) == $past($countones(vld)) + 1)
		else $error("insert did not add exactly one entry");

	a_no_silent_insert: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> !rsp_valid || $past(rsp_valid && !rsp_ready))
		else $error("successful insert produced a response");

endmodule
